>>> rtl/psa_pkg.sv
// ----------------------------------------------------------------------------
// psa_pkg: shared types and constants for the page slot allocator
// Request and response words, request codes and sequencer states.
// ----------------------------------------------------------------------------
package psa_pkg;

	// address geometry
	localparam int VA_W        = 24;
	localparam int PA_W        = 48;
	localparam int PAGE_SHIFT  = 12;
	localparam int SLOT_IDX_W  = VA_W - PAGE_SHIFT;
	// reciprocal operand: up to 2^SLOT_IDX_W
	localparam int RECIP_W     = SLOT_IDX_W + 1;

	// request codes
	typedef enum logic [1:0] {
		MODE_ALLOC = 2'd0,
		MODE_FREE  = 2'd1,
		MODE_CHECK = 2'd2
	} mode_t;

	// request word
	typedef struct packed {
		logic [1:0]      mode;
		logic [VA_W-1:0] virtual_address;
	} req_t;

	// response word
	typedef struct packed {
		logic            ok;
		logic [VA_W-1:0] page_address;
		logic [PA_W-1:0] physical_address;
	} resp_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_PAGE,
		ST_SLOT_MUL,
		ST_ALLOC_WR,
		ST_DIV_MUL,
		ST_DIV_Q,
		ST_DIV_FIX,
		ST_FC_RD,
		ST_FC,
		ST_DONE
	} state_t;

endpackage

>>> rtl/psa_mul.sv
// ----------------------------------------------------------------------------
// psa_mul: shared multiplier
// Registered unsigned product; used for slot split and slot number build.
// ----------------------------------------------------------------------------
module psa_mul #(
	parameter int A_W = 16,
	parameter int B_W = 13
) (
	input  logic               clk,
	input  logic [A_W-1:0]     a,
	input  logic [B_W-1:0]     b,
	output logic [A_W+B_W-1:0] prod_q
);

	// one product per cycle, registered result
	always_ff @(posedge clk) begin
		prod_q <= (A_W+B_W)'(a) * (A_W+B_W)'(b);
	end

endmodule

>>> rtl/psa_row_store.sv
// ----------------------------------------------------------------------------
// psa_row_store: descriptor row memory
// One row per descriptor: page count over the page bitmap. Registered read.
// ----------------------------------------------------------------------------
module psa_row_store #(
	parameter int DEPTH = 256,
	parameter int AW    = 8,
	parameter int RW    = 21
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [RW-1:0] rd_data_q,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [RW-1:0] wr_data
);

	logic [RW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

endmodule

>>> rtl/psa_seq.sv
// ----------------------------------------------------------------------------
// psa_seq: allocator sequencer
// Clears the row store, scans descriptors and pages, splits slot numbers
// through the shared multiplier and builds the response word.
// ----------------------------------------------------------------------------
module psa_seq
	import psa_pkg::*;
#(
	parameter int TOTAL_DESC = 256,
	parameter int PAGES      = 16,
	parameter int DW         = 8,
	parameter int PW         = 4,
	parameter int CW         = 5,
	parameter int SW         = 12,
	parameter int A_W        = 12,
	parameter int B_W        = 13
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [PA_W-1:0]      region_base,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 resp_valid,
	input  logic                 resp_stall,
	output resp_t                resp,
	// row store
	output logic                 rd_en,
	output logic [DW-1:0]        rd_addr,
	input  logic [CW+PAGES-1:0]  rd_data,
	output logic                 wr_en,
	output logic [DW-1:0]        wr_addr,
	output logic [CW+PAGES-1:0]  wr_data,
	// shared multiplier
	output logic [A_W-1:0]       mul_a,
	output logic [B_W-1:0]       mul_b,
	input  logic [A_W+B_W-1:0]   prod
);

	localparam int RW = CW + PAGES;
	// floor(2^SLOT_IDX_W / PAGES): quotient estimate is low by at most one
	localparam int RECIP = (1 << SLOT_IDX_W) / PAGES;
	localparam logic [24:0] TOTAL_SLOTS = 25'(TOTAL_DESC * PAGES);

	state_t                state_q, state_d;
	logic [1:0]            mode_q, mode_d;
	logic [SLOT_IDX_W-1:0] slot_q, slot_d;
	logic [DW-1:0]         desc_q, desc_d;
	logic [PW-1:0]         page_q, page_d;
	logic [RW-1:0]         row_q, row_d;
	resp_t                 res_q, res_d;
	resp_t                 resp_q;
	logic                  resp_valid_q;
	logic                  load_resp;

	logic [SLOT_IDX_W-1:0] req_slot;
	logic [SLOT_IDX_W-1:0] quot0;
	logic [SLOT_IDX_W-1:0] rem0;
	logic [RW-1:0]         bit_mask;
	logic [CW-1:0]         rd_count;
	logic [CW-1:0]         row_count;
	logic [SW-1:0]         slot_num;
	logic [PAGE_SHIFT+SW-1:0] slot_addr;

	assign req_slot  = req.virtual_address[VA_W-1:PAGE_SHIFT];
	assign quot0     = prod[SLOT_IDX_W +: SLOT_IDX_W];
	assign rem0      = slot_q - prod[SLOT_IDX_W-1:0];
	assign bit_mask  = RW'(1) << page_q;
	assign rd_count  = rd_data[RW-1:PAGES];
	assign row_count = row_q[RW-1:PAGES];
	assign slot_num  = prod[SW-1:0] + SW'(page_q);
	assign slot_addr = {slot_num, {PAGE_SHIFT{1'b0}}};

	assign req_stall  = (state_q != ST_IDLE);
	assign resp_valid = resp_valid_q;
	assign resp       = resp_q;

	// next state and datapath control
	always_comb begin
		state_d   = state_q;
		mode_d    = mode_q;
		slot_d    = slot_q;
		desc_d    = desc_q;
		page_d    = page_q;
		row_d     = row_q;
		res_d     = res_q;
		load_resp = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = desc_q;
		wr_en     = 1'b0;
		wr_addr   = desc_q;
		wr_data   = '0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			// zero every row after reset
			ST_CLEAR: begin
				wr_en = 1'b1;
				if (desc_q == DW'(TOTAL_DESC - 1)) begin
					desc_d  = '0;
					state_d = ST_IDLE;
				end else begin
					desc_d = desc_q + DW'(1);
				end
			end
			ST_IDLE: begin
				if (req_valid) begin
					mode_d = req.mode;
					slot_d = req_slot;
					res_d  = '0;
					case (req.mode)
						MODE_ALLOC: begin
							desc_d  = '0;
							state_d = ST_SCAN_RD;
						end
						MODE_FREE, MODE_CHECK: begin
							if (25'(req_slot) < TOTAL_SLOTS) begin
								state_d = ST_DIV_MUL;
							end else begin
								state_d = ST_DONE;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			// first descriptor that is not full
			ST_SCAN_RD: begin
				rd_en   = 1'b1;
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (rd_count < CW'(PAGES)) begin
					row_d   = rd_data;
					page_d  = '0;
					state_d = ST_PAGE;
				end else if (desc_q == DW'(TOTAL_DESC - 1)) begin
					state_d = ST_DONE;
				end else begin
					desc_d  = desc_q + DW'(1);
					state_d = ST_SCAN_RD;
				end
			end
			// first free page, one bit a cycle
			ST_PAGE: begin
				if (!row_q[page_q]) begin
					state_d = ST_SLOT_MUL;
				end else if (page_q == PW'(PAGES - 1)) begin
					state_d = ST_DONE;
				end else begin
					page_d = page_q + PW'(1);
				end
			end
			ST_SLOT_MUL: begin
				mul_a   = A_W'(desc_q);
				mul_b   = B_W'(PAGES);
				state_d = ST_ALLOC_WR;
			end
			// mark the page used and form both addresses
			ST_ALLOC_WR: begin
				wr_en   = 1'b1;
				wr_data = {row_count + CW'(1), row_q[PAGES-1:0] | bit_mask[PAGES-1:0]};
				res_d.ok               = 1'b1;
				res_d.page_address     = VA_W'(slot_addr);
				res_d.physical_address = region_base + PA_W'(slot_addr);
				state_d = ST_DONE;
			end
			// slot split: estimate quotient by reciprocal
			ST_DIV_MUL: begin
				mul_a   = A_W'(slot_q);
				mul_b   = B_W'(RECIP);
				state_d = ST_DIV_Q;
			end
			ST_DIV_Q: begin
				desc_d  = DW'(quot0);
				mul_a   = A_W'(quot0);
				mul_b   = B_W'(PAGES);
				state_d = ST_DIV_FIX;
			end
			// one correction step on the remainder
			ST_DIV_FIX: begin
				if (rem0 >= SLOT_IDX_W'(PAGES)) begin
					desc_d = desc_q + DW'(1);
					page_d = PW'(rem0 - SLOT_IDX_W'(PAGES));
				end else begin
					page_d = PW'(rem0);
				end
				state_d = ST_FC_RD;
			end
			ST_FC_RD: begin
				rd_en   = 1'b1;
				state_d = ST_FC;
			end
			// free or check on the addressed page
			ST_FC: begin
				res_d.ok = rd_data[page_q];
				if (mode_q == MODE_FREE && rd_data[page_q]) begin
					wr_en   = 1'b1;
					wr_data = rd_data & ~bit_mask;
					if (rd_count != '0) begin
						wr_data[RW-1:PAGES] = rd_count - CW'(1);
					end
				end
				state_d = ST_DONE;
			end
			// hand over once the output register is free
			ST_DONE: begin
				if (!resp_valid_q || !resp_stall) begin
					load_resp = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			desc_q       <= '0;
			resp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			desc_q  <= desc_d;
			if (load_resp) begin
				resp_valid_q <= 1'b1;
			end else if (!resp_stall) begin
				resp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		mode_q <= mode_d;
		slot_q <= slot_d;
		page_q <= page_d;
		row_q  <= row_d;
		res_q  <= res_d;
		if (load_resp) begin
			resp_q <= res_q;
		end
	end

endmodule

>>> rtl/page_slot_allocator.sv
// ----------------------------------------------------------------------------
// page_slot_allocator: first-fit bitmap page slot allocator
// Allocate scans the descriptors, then tests the pages of the first one that is
// not full; free and check split the slot number and read one row; rejected
// requests go straight to the response. One word at a time. The descriptor scan
// reads each row store entry, then checks it. Reset: a clearing pass zeroes the
// row store; no request word is taken meanwhile. region_base resets to zero.
// ----------------------------------------------------------------------------
module page_slot_allocator
	import psa_pkg::*;
#(
	parameter int ROOT_TABLES          = 16,
	parameter int DESCRIPTORS          = 16,
	parameter int PAGES_PER_DESCRIPTOR = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            region_base_we,
	input  logic [PA_W-1:0] region_base_wdata,
	input  logic            req_valid,
	output logic            req_stall,
	input  req_t            req,
	output logic            resp_valid,
	input  logic            resp_stall,
	output resp_t           resp
);

	localparam int TOTAL_DESC = ROOT_TABLES * DESCRIPTORS;
	localparam int TOTAL_SLOT = TOTAL_DESC * PAGES_PER_DESCRIPTOR;
	localparam int DW  = (TOTAL_DESC > 1) ? $clog2(TOTAL_DESC) : 1;
	localparam int PW  = (PAGES_PER_DESCRIPTOR > 1) ? $clog2(PAGES_PER_DESCRIPTOR) : 1;
	localparam int CW  = $clog2(PAGES_PER_DESCRIPTOR + 1);
	localparam int SW  = (TOTAL_SLOT > 1) ? $clog2(TOTAL_SLOT) : 1;
	localparam int RW  = CW + PAGES_PER_DESCRIPTOR;
	localparam int A_W = (DW > SLOT_IDX_W) ? DW : SLOT_IDX_W;
	localparam int B_W = RECIP_W;

	logic [PA_W-1:0]    region_base_q;
	logic               rd_en;
	logic [DW-1:0]      rd_addr;
	logic [RW-1:0]      rd_data;
	logic               wr_en;
	logic [DW-1:0]      wr_addr;
	logic [RW-1:0]      wr_data;
	logic [A_W-1:0]     mul_a;
	logic [B_W-1:0]     mul_b;
	logic [A_W+B_W-1:0] prod;

	// region base register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_base_q <= '0;
		end else if (region_base_we) begin
			region_base_q <= region_base_wdata;
		end
	end

	psa_seq #(
		.TOTAL_DESC (TOTAL_DESC),
		.PAGES      (PAGES_PER_DESCRIPTOR),
		.DW         (DW),
		.PW         (PW),
		.CW         (CW),
		.SW         (SW),
		.A_W        (A_W),
		.B_W        (B_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.region_base (region_base_q),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.req         (req),
		.resp_valid  (resp_valid),
		.resp_stall  (resp_stall),
		.resp        (resp),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.mul_a       (mul_a),
		.mul_b       (mul_b),
		.prod        (prod)
	);

	psa_row_store #(
		.DEPTH (TOTAL_DESC),
		.AW    (DW),
		.RW    (RW)
	) u_rows (
		.clk       (clk),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data_q (rd_data),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data)
	);

	psa_mul #(
		.A_W (A_W),
		.B_W (B_W)
	) u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod)
	);

endmodule

>>> tb/sv/page_slot_allocator_tb.sv
// ----------------------------------------------------------------------------
// page_slot_allocator_tb: self-checking bench for the page slot allocator
// A directed table, then random request words. A local mirror of the slot
// bitmap and descriptor counts predicts each response word that the table does
// not type in. Both channels idle at random; region_base changes between phases.
// ----------------------------------------------------------------------------
module page_slot_allocator_tb;
	import psa_pkg::*;

	// allocator geometry
	localparam int ROOTS     = 16;
	localparam int DESCS     = 16;
	localparam int PAGES     = 16;
	localparam int NUM_DESC  = ROOTS * DESCS;
	localparam int NUM_SLOTS = NUM_DESC * PAGES;

	// unused request code
	localparam logic [1:0] MODE_RSVD = 2'd3;

	localparam int     IDLE_PCT     = 21;
	localparam int     RAND_PHASES  = 5;
	localparam int     PHASE_ITEMS  = 130;
	localparam int     DRAIN_CYCLES = 2 * NUM_DESC + PAGES + 16;
	localparam longint CYCLE_LIMIT  = 10_000_000;

	// one directed row: request, and a typed-in response where one is given
	typedef struct packed {
		logic [1:0]      mode;
		logic [VA_W-1:0] va;
		logic            typed;
		resp_t           want;
	} stim_row_t;

	logic            clk;
	logic            arst_n;
	logic            region_base_we;
	logic [PA_W-1:0] region_base_wdata;
	logic            req_valid;
	logic            req_stall;
	req_t            req;
	logic            resp_valid;
	logic            resp_stall = 1'b0;
	resp_t           resp;

	// allocator mirror
	bit              slot_busy [NUM_SLOTS];
	int              desc_fill [NUM_DESC];
	logic [PA_W-1:0] base_mirror;
	int              busy_slots[$];

	resp_t     pending_resp[$];
	stim_row_t stim_rows[$];
	bit        idle_en     = 1'b1;
	int        error_count = 0;
	longint    cycle_count = 0;

	page_slot_allocator #(
		.ROOT_TABLES         (ROOTS),
		.DESCRIPTORS         (DESCS),
		.PAGES_PER_DESCRIPTOR(PAGES)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.region_base_we   (region_base_we),
		.region_base_wdata(region_base_wdata),
		.req_valid        (req_valid),
		.req_stall        (req_stall),
		.req              (req),
		.resp_valid       (resp_valid),
		.resp_stall       (resp_stall),
		.resp             (resp)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// first-fit allocation, free and check against the mirror
	function automatic resp_t allocator_response(input req_t r);
		resp_t                 o;
		int                    d;
		int                    p;
		int                    s;
		int                    slot;
		int                    i;
		bit                    hit;
		logic [SLOT_IDX_W-1:0] sidx;
		o    = '0;
		slot = int'(r.virtual_address[VA_W-1:PAGE_SHIFT]);
		hit  = 1'b0;
		s    = 0;
		case (r.mode)
			MODE_ALLOC: begin
				d = 0;
				while (d < NUM_DESC && desc_fill[d] >= PAGES)
					d++;
				if (d < NUM_DESC) begin
					for (p = 0; p < PAGES && !hit; p++) begin
						s   = d * PAGES + p;
						hit = !slot_busy[s];
					end
				end
				if (hit) begin
					slot_busy[s] = 1'b1;
					desc_fill[d]++;
					busy_slots.push_back(s);
					sidx                = s[SLOT_IDX_W-1:0];
					o.ok                = 1'b1;
					o.page_address      = {sidx, {PAGE_SHIFT{1'b0}}};
					o.physical_address  = base_mirror +
						{{(PA_W-VA_W){1'b0}}, sidx, {PAGE_SHIFT{1'b0}}};
				end
			end
			MODE_FREE: begin
				if (slot < NUM_SLOTS && slot_busy[slot]) begin
					slot_busy[slot] = 1'b0;
					if (desc_fill[slot / PAGES] != 0)
						desc_fill[slot / PAGES]--;
					for (i = 0; i < busy_slots.size(); i++) begin
						if (busy_slots[i] == slot) begin
							busy_slots.delete(i);
							break;
						end
					end
					o.ok = 1'b1;
				end
			end
			MODE_CHECK: begin
				o.ok = (slot < NUM_SLOTS) && slot_busy[slot];
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic stim_row_t stim_row(input logic [1:0] m, input logic [VA_W-1:0] va,
			input logic typed, input logic ok, input logic [VA_W-1:0] pa,
			input logic [PA_W-1:0] pha);
		return {m, va, typed, ok, pa, pha};
	endfunction

	// send one request word; the expectation is queued when it is taken
	task automatic issue(input req_t r, input bit typed, input resp_t want);
		resp_t model_resp;
		if (idle_en && $urandom_range(99) < IDLE_PCT) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= r;
		do @(posedge clk); while (req_stall);
		model_resp = allocator_response(r);
		pending_resp.push_back(typed ? want : model_resp);
	endtask

	task automatic play_rows();
		req_t r;
		int   i;
		for (i = 0; i < stim_rows.size(); i++) begin
			r.mode            = stim_rows[i].mode;
			r.virtual_address = stim_rows[i].va;
			issue(r, stim_rows[i].typed, stim_rows[i].want);
		end
	endtask

	// region_base is only written once the block has nothing in flight
	task automatic write_base(input logic [PA_W-1:0] v);
		req_valid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
		region_base_we    <= 1'b1;
		region_base_wdata <= v;
		@(posedge clk);
		region_base_we <= 1'b0;
		base_mirror     = v;
	endtask

	// mostly allocate, free and check of live slots; some noise
	task automatic random_item(output req_t r);
		int          pick;
		int          sel;
		logic [31:0] w;
		pick              = $urandom_range(99);
		w                 = $urandom;
		r.mode            = MODE_ALLOC;
		r.virtual_address = w[VA_W-1:0];
		if (pick >= 40) begin
			if (pick < 62 || (pick >= 70 && pick < 85)) begin
				if (busy_slots.size() != 0) begin
					sel = busy_slots[$urandom_range(busy_slots.size() - 1)];
					r.virtual_address = {sel[SLOT_IDX_W-1:0], w[PAGE_SHIFT-1:0]};
					r.mode            = (pick < 62) ? MODE_FREE : MODE_CHECK;
				end
			end else begin
				r.mode = (pick < 70) ? MODE_FREE : (pick < 95) ? MODE_CHECK : MODE_RSVD;
			end
		end
	endtask

	// response side: random stall, compare each taken word
	always @(posedge clk) begin : resp_check
		resp_t want;
		resp_stall <= idle_en && ($urandom_range(99) < IDLE_PCT);
		if (arst_n && resp_valid && !resp_stall) begin
			if (pending_resp.size() == 0) begin
				$error("response word with nothing expected");
				error_count++;
			end else begin
				want = pending_resp.pop_front();
				if (resp.ok !== want.ok) begin
					$error("ok: expected %0d, got %0d", want.ok, resp.ok);
					error_count++;
				end
				if (resp.page_address !== want.page_address) begin
					$error("page_address: expected %h, got %h",
						want.page_address, resp.page_address);
					error_count++;
				end
				if (resp.physical_address !== want.physical_address) begin
					$error("physical_address: expected %h, got %h",
						want.physical_address, resp.physical_address);
					error_count++;
				end
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("page_slot_allocator test failed");
			$finish;
		end
	end

	initial begin
		req_t            r;
		logic [63:0]     w64;
		logic [PA_W-1:0] phase_base;
		int              ph;
		int              i;

		arst_n            <= 1'b0;
		req_valid         <= 1'b0;
		req               <= '0;
		region_base_we    <= 1'b0;
		region_base_wdata <= '0;
		base_mirror        = '0;
		for (i = 0; i < NUM_SLOTS; i++)
			slot_busy[i] = 1'b0;
		for (i = 0; i < NUM_DESC; i++)
			desc_fill[i] = 0;

		// directed: region_base still at its reset value of zero
		stim_rows.push_back(stim_row(MODE_CHECK, 24'h000000, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_FREE,  24'h000000, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'h000000, 1, 1, 24'h000000, 48'h0));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'hFFFFFF, 1, 1, 24'h001000, 48'h1000));
		stim_rows.push_back(stim_row(MODE_CHECK, 24'h000FFF, 1, 1, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_CHECK, 24'hFFF000, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_CHECK, 24'hFFFFFF, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_RSVD,  24'hFFFFFF, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_RSVD,  24'h000000, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_FREE,  24'h001ABC, 1, 1, 24'h0, 48'h0));
		// double free
		stim_rows.push_back(stim_row(MODE_FREE,  24'h001000, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'h000000, 1, 1, 24'h001000, 48'h1000));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'h000000, 0, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_FREE,  24'h000000, 1, 1, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'h000000, 1, 1, 24'h000000, 48'h0));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'hFFFFFF, 0, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_FREE,  24'hFFFFFF, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_CHECK, 24'h003000, 0, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_FREE,  24'h002FFF, 0, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_ALLOC, 24'h000000, 0, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_CHECK, 24'hAAA555, 1, 0, 24'h0, 48'h0));
		stim_rows.push_back(stim_row(MODE_CHECK, 24'h555AAA, 1, 0, 24'h0, 48'h0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		play_rows();

		// random phases, each under its own region_base; one runs without idling
		for (ph = 0; ph < RAND_PHASES; ph++) begin
			w64 = {$urandom, $urandom};
			case (ph)
				0:       phase_base = 48'hFFFF_FFFF_FFFF;
				2:       phase_base = 48'h0;
				4:       phase_base = 48'hFFFF_FFFF_F000;
				default: phase_base = w64[PA_W-1:0];
			endcase
			write_base(phase_base);
			idle_en = (ph != 2);
			repeat (PHASE_ITEMS) begin
				random_item(r);
				issue(r, 1'b0, '0);
			end
		end
		idle_en = 1'b1;

		// drain
		req_valid <= 1'b0;
		while (pending_resp.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("page_slot_allocator test passed");
		else
			$display("page_slot_allocator test failed");
		$finish;
	end

endmodule
